### sv/red_blob_centroid_slope_top_assert.svh
// assertion macros shared by the red blob centroid and slope block
`ifndef RED_BLOB_CENTROID_SLOPE_TOP_ASSERT_SVH
`define RED_BLOB_CENTROID_SLOPE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define RBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbc assertion failed");

// condition implies consequence in the next cycle
`define RBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbc assertion failed");

`endif

### sv/rbc_pkg.sv
// types, constants and codes for the red blob centroid and slope block
`timescale 1ns / 1ps
`default_nettype none
package rbc_pkg;

    localparam int COORD_BITS         = 10;
    localparam int CENTROID_FRAC_BITS = 8;
    localparam int SLOPE_FRAC_BITS    = 16;

    localparam int DC_W            = (COORD_BITS > 10 ? COORD_BITS : 10) + 1;
    localparam int MUL_STEPS       = 32;
    localparam int QUO_W           = 32 + SLOPE_FRAC_BITS + 1;
    localparam int DIV_MEAN_ITERS  = 64;
    localparam int DIV_SLOPE_ITERS = 64 + SLOPE_FRAC_BITS + 1;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = 2;

    localparam logic [20:0] RED_CAP = 21'h100000;

    // register indexes
    localparam logic [1:0] CFG_RED_RATIO  = 2'd0;
    localparam logic [1:0] CFG_CENTER_COL = 2'd1;
    localparam logic [1:0] CFG_CENTER_ROW = 2'd2;

    // result codes
    localparam logic       KIND_MASK       = 1'b0;
    localparam logic       KIND_SUMMARY    = 1'b1;
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_RED   = 2'd1;
    localparam logic [1:0] STATUS_DEN_ZERO = 2'd2;

    typedef struct packed {
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
        logic       frame_start;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        logic               kind;
        logic               is_red;
        logic [20:0]        red_total;
        logic [17:0]        centroid_col_fx;
        logic [17:0]        centroid_row_fx;
        logic signed [31:0] slope_fx;
        logic [1:0]         status;
        logic               last;
    } result_t;

    typedef struct packed {
        logic                  red;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  frame_start;
        logic                  frame_end;
    } entry_t;

    typedef struct packed {
        logic [7:0] red_ratio;
        logic [9:0] center_col;
        logic [9:0] center_row;
    } cfg_t;

endpackage
`default_nettype wire

### sv/rbc_front.sv
// front end: configuration registers and red classification of each pixel
`timescale 1ns / 1ps
`default_nettype none
module rbc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [9:0]      cfg_data,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire rbc_pkg::pixel_t pixel,
    input  wire logic            fifo_full,
    output logic                 push,
    output rbc_pkg::entry_t      push_entry,
    output rbc_pkg::cfg_t        cfg
);

    rbc_pkg::cfg_t cfg_reg;
    logic [9:0]    gb_sum;
    logic [8:0]    ratio_p1;
    logic [18:0]   thresh;
    logic [8:0]    red_p1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_ratio  <= 8'd10;
            cfg_reg.center_col <= 10'd320;
            cfg_reg.center_row <= 10'd240;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbc_pkg::CFG_RED_RATIO:  cfg_reg.red_ratio  <= cfg_data[7:0];
                rbc_pkg::CFG_CENTER_COL: cfg_reg.center_col <= cfg_data;
                rbc_pkg::CFG_CENTER_ROW: cfg_reg.center_row <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // red test r+1 >= (ratio+1)*(g+b+2)
    always_comb
    begin
        gb_sum   = 10'(pixel.green_level) + 10'(pixel.blue_level) + 10'd2;
        ratio_p1 = 9'(cfg_reg.red_ratio) + 9'd1;
        thresh   = 19'(ratio_p1) * 19'(gb_sum);
        red_p1   = 9'(pixel.red_level) + 9'd1;
    end

    // item into the queue
    assign in_stall               = fifo_full;
    assign push                   = in_valid && !fifo_full;
    assign push_entry.red         = 19'(red_p1) >= thresh;
    assign push_entry.col         = rbc_pkg::COORD_BITS'(pixel.pixel_col);
    assign push_entry.row         = rbc_pkg::COORD_BITS'(pixel.pixel_row);
    assign push_entry.frame_start = pixel.frame_start;
    assign push_entry.frame_end   = pixel.frame_end;

endmodule
`default_nettype wire

### sv/rbc_fifo.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps
`default_nettype none
module rbc_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rbc_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output rbc_pkg::entry_t      head
);

    rbc_pkg::entry_t             mem [rbc_pkg::FIFO_DEPTH];
    logic [rbc_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [rbc_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [rbc_pkg::FIFO_AW:0]   count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full      = count_reg == (rbc_pkg::FIFO_AW + 1)'(rbc_pkg::FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

endmodule
`default_nettype wire

### sv/rbc_back.sv
// back end: accumulation, mask results and the frame summary sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "red_blob_centroid_slope_top_assert.svh"
module rbc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rbc_pkg::cfg_t   cfg,
    input  wire logic            fifo_valid,
    input  wire rbc_pkg::entry_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output rbc_pkg::result_t     result
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_MLOAD, ST_MUL, ST_DLOAD, ST_DIV, ST_OUT
    } state_t;

    state_t                   state_reg;
    logic                     out_valid_reg;
    rbc_pkg::result_t         result_reg;
    logic [20:0]              cnt_reg;
    logic [30:0]              scol_reg;
    logic [30:0]              srow_reg;
    logic [39:0]              sqq_reg;
    logic signed [41:0]       sdd_reg;
    logic signed [32:0]       sx_reg;
    logic signed [32:0]       sy_reg;
    logic [1:0]               mi_reg;
    logic [63:0]              mc_reg;
    logic [31:0]              mp_reg;
    logic [63:0]              acc_reg;
    logic                     neg_reg;
    logic [5:0]               step_reg;
    logic signed [63:0]       t_reg;
    logic signed [63:0]       num_reg;
    logic signed [63:0]       den_reg;
    logic [1:0]               dj_reg;
    logic [63:0]              dvd_reg;
    logic [64:0]              rem_reg;
    logic [62:0]              div_reg;
    logic [rbc_pkg::QUO_W-1:0] quo_reg;
    logic                     ovf_reg;
    logic [6:0]               it_reg;
    logic [6:0]               iters_reg;
    logic [17:0]              ccol_reg;
    logic [17:0]              crow_reg;
    logic signed [31:0]       slope_reg;
    logic [1:0]               stat_reg;

    // accumulation terms
    logic                     out_free;
    logic [20:0]              cnt_base;
    logic [30:0]              scol_base;
    logic [30:0]              srow_base;
    logic [39:0]              sqq_base;
    logic signed [41:0]       sdd_base;
    logic                     acc_en;
    logic signed [rbc_pkg::DC_W-1:0]   dc;
    logic signed [rbc_pkg::DC_W-1:0]   dr;
    logic signed [2*rbc_pkg::DC_W-1:0] dcsq;
    logic signed [2*rbc_pkg::DC_W-1:0] dcdr;

    // summary terms
    logic [30:0]              ncc;
    logic [30:0]              ncr;
    logic [31:0]              sx_mag;
    logic [31:0]              sy_mag;
    logic [41:0]              sdd_neg;
    logic [63:0]              sdd_mag;
    logic [63:0]              ld_a;
    logic [31:0]              ld_b;
    logic                     ld_neg;
    logic signed [63:0]       prod;
    logic [63:0]              num_mag;
    logic [64:0]              rem_sh;
    logic                     fits;
    logic [64:0]              rem_step;
    logic [rbc_pkg::QUO_W:0]  m_rnd;
    logic [rbc_pkg::QUO_W:0]  m_lim;
    logic [rbc_pkg::QUO_W:0]  m_sat;
    logic [63:0]              mean_dvd;

    // output register load
    logic                     out_load;
    rbc_pkg::result_t         result_next;

    // per-pixel accumulation
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        pop       = (state_reg == ST_IDLE) && fifo_valid && out_free;
        cnt_base  = head.frame_start ? '0 : cnt_reg;
        scol_base = head.frame_start ? '0 : scol_reg;
        srow_base = head.frame_start ? '0 : srow_reg;
        sqq_base  = head.frame_start ? '0 : sqq_reg;
        sdd_base  = head.frame_start ? '0 : sdd_reg;
        acc_en    = head.red && (cnt_base < rbc_pkg::RED_CAP);
        dc        = $signed(rbc_pkg::DC_W'(head.col)) - $signed(rbc_pkg::DC_W'(cfg.center_col));
        dr        = $signed(rbc_pkg::DC_W'(head.row)) - $signed(rbc_pkg::DC_W'(cfg.center_row));
        dcsq      = dc * dc;
        dcdr      = dc * dr;
    end

    // multiplier operands for the four moment products
    always_comb
    begin
        ncc     = 31'(cnt_reg) * 31'(cfg.center_col);
        ncr     = 31'(cnt_reg) * 31'(cfg.center_row);
        sx_mag  = sx_reg[32] ? 32'(-sx_reg) : 32'(sx_reg);
        sy_mag  = sy_reg[32] ? 32'(-sy_reg) : 32'(sy_reg);
        sdd_neg = -sdd_reg;
        sdd_mag = sdd_reg[41] ? {22'b0, sdd_neg} : {22'b0, sdd_reg};
        case (mi_reg)
            2'd0:
            begin
                ld_a   = sdd_mag;
                ld_b   = 32'(cnt_reg);
                ld_neg = sdd_reg[41];
            end
            2'd1:
            begin
                ld_a   = 64'(sx_mag);
                ld_b   = sy_mag;
                ld_neg = sx_reg[32] ^ sy_reg[32];
            end
            2'd2:
            begin
                ld_a   = 64'(sqq_reg);
                ld_b   = 32'(cnt_reg);
                ld_neg = 1'b0;
            end
            default:
            begin
                ld_a   = 64'(sx_mag);
                ld_b   = sx_mag;
                ld_neg = 1'b0;
            end
        endcase
        prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    end

    // divider step and slope rounding
    always_comb
    begin
        num_mag  = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
        mean_dvd = (dj_reg == 2'd0)
                 ? (64'(scol_reg) << rbc_pkg::CENTROID_FRAC_BITS) + 64'(cnt_reg >> 1)
                 : (64'(srow_reg) << rbc_pkg::CENTROID_FRAC_BITS) + 64'(cnt_reg >> 1);
        rem_sh   = {rem_reg[63:0], dvd_reg[63]};
        fits     = rem_sh >= {2'b0, div_reg};
        rem_step = fits ? rem_sh - {2'b0, div_reg} : rem_sh;
        m_rnd    = ({1'b0, quo_reg} + 1'b1) >> 1;
        m_lim    = neg_reg ? (rbc_pkg::QUO_W + 1)'(33'h080000000)
                           : (rbc_pkg::QUO_W + 1)'(33'h07FFFFFFF);
        m_sat    = (ovf_reg || m_rnd > m_lim) ? m_lim : m_rnd;
    end

    // next output item: mask item on a pop, summary item on leaving the output state
    always_comb
    begin
        out_load    = pop || ((state_reg == ST_OUT) && out_free);
        result_next = '0;
        if (pop)
        begin
            result_next.kind   = rbc_pkg::KIND_MASK;
            result_next.is_red = head.red;
            result_next.last   = !head.frame_end;
        end
        else
        begin
            result_next.kind            = rbc_pkg::KIND_SUMMARY;
            result_next.is_red          = 1'b0;
            result_next.red_total       = cnt_reg;
            result_next.centroid_col_fx = ccol_reg;
            result_next.centroid_row_fx = crow_reg;
            result_next.slope_fx        = slope_reg;
            result_next.status          = stat_reg;
            result_next.last            = 1'b1;
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            cnt_reg       <= '0;
            scol_reg      <= '0;
            srow_reg      <= '0;
            sqq_reg       <= '0;
            sdd_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            mi_reg        <= '0;
            mc_reg        <= '0;
            mp_reg        <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            step_reg      <= '0;
            t_reg         <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            dj_reg        <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            quo_reg       <= '0;
            ovf_reg       <= 1'b0;
            it_reg        <= '0;
            iters_reg     <= '0;
            ccol_reg      <= '0;
            crow_reg      <= '0;
            slope_reg     <= '0;
            stat_reg      <= rbc_pkg::STATUS_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                result_reg    <= result_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cnt_reg  <= acc_en ? cnt_base + 1'b1 : cnt_base;
                        scol_reg <= acc_en ? scol_base + 31'(head.col) : scol_base;
                        srow_reg <= acc_en ? srow_base + 31'(head.row) : srow_base;
                        sqq_reg  <= acc_en ? sqq_base + 40'(dcsq) : sqq_base;
                        sdd_reg  <= acc_en ? sdd_base + 42'(dcdr) : sdd_base;
                        if (head.frame_end)
                        begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP:
                begin
                    ccol_reg  <= '0;
                    crow_reg  <= '0;
                    slope_reg <= '0;
                    mi_reg    <= '0;
                    dj_reg    <= '0;
                    if (cnt_reg == '0)
                    begin
                        stat_reg  <= rbc_pkg::STATUS_NO_RED;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        stat_reg  <= rbc_pkg::STATUS_OK;
                        sx_reg    <= $signed({2'b0, scol_reg}) - $signed({2'b0, ncc});
                        sy_reg    <= $signed({2'b0, srow_reg}) - $signed({2'b0, ncr});
                        state_reg <= ST_MLOAD;
                    end
                end
                ST_MLOAD:
                begin
                    mc_reg    <= ld_a;
                    mp_reg    <= ld_b;
                    neg_reg   <= ld_neg;
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (step_reg == 6'(rbc_pkg::MUL_STEPS))
                    begin
                        case (mi_reg)
                            2'd0:    t_reg   <= prod;
                            2'd1:    num_reg <= t_reg - prod;
                            2'd2:    t_reg   <= prod;
                            default: den_reg <= t_reg - prod;
                        endcase
                        mi_reg    <= mi_reg + 1'b1;
                        state_reg <= (mi_reg == 2'd3) ? ST_DLOAD : ST_MLOAD;
                    end
                    else
                    begin
                        if (mp_reg[0])
                        begin
                            acc_reg <= acc_reg + mc_reg;
                        end
                        mc_reg   <= mc_reg << 1;
                        mp_reg   <= mp_reg >> 1;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DLOAD:
                begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                    it_reg  <= '0;
                    if (dj_reg != 2'd2)
                    begin
                        dvd_reg   <= mean_dvd;
                        div_reg   <= 63'(cnt_reg);
                        iters_reg <= 7'(rbc_pkg::DIV_MEAN_ITERS);
                        state_reg <= ST_DIV;
                    end
                    else if (den_reg <= 0)
                    begin
                        stat_reg  <= rbc_pkg::STATUS_DEN_ZERO;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        dvd_reg   <= num_mag;
                        div_reg   <= 63'(den_reg);
                        neg_reg   <= num_reg[63];
                        iters_reg <= 7'(rbc_pkg::DIV_SLOPE_ITERS);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (it_reg == iters_reg)
                    begin
                        case (dj_reg)
                            2'd0:    ccol_reg  <= quo_reg[17:0];
                            2'd1:    crow_reg  <= quo_reg[17:0];
                            default: slope_reg <= neg_reg ? 32'(-m_sat) : 32'(m_sat);
                        endcase
                        dj_reg    <= dj_reg + 1'b1;
                        state_reg <= (dj_reg == 2'd2) ? ST_OUT : ST_DLOAD;
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        dvd_reg <= dvd_reg << 1;
                        quo_reg <= {quo_reg[rbc_pkg::QUO_W-2:0], fits};
                        ovf_reg <= ovf_reg | quo_reg[rbc_pkg::QUO_W-1];
                        it_reg  <= it_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // checks
    `RBC_ASSERT_IMP(a_pop_has_item, clk, rst_n, pop, fifo_valid)
    `RBC_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, div_reg != '0)
    `RBC_ASSERT_NXT(a_end_to_summary, clk, rst_n, pop && head.frame_end, state_reg == ST_PREP)

endmodule
`default_nettype wire

### sv/red_blob_centroid_slope_top.sv
// mask item: the pixel is written into the queue when taken and registered as it leaves the queue
// throughput: one pixel per cycle in a frame while out_stall is low, set by queue and accumulators
// frame end: summary work of four serial multiplies and up to three restoring divisions
// (centroid col and row, slope), none with no red pixels, before the back takes more
// reset: asynchronous, active low; clears accumulators, queue and control, and sets
// red_ratio 10, center_col 320, center_row 240
`timescale 1ns / 1ps
`default_nettype none
module red_blob_centroid_slope_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [9:0]       cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire rbc_pkg::pixel_t  pixel,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rbc_pkg::result_t      result
);

    rbc_pkg::cfg_t   cfg;
    rbc_pkg::entry_t push_entry;
    rbc_pkg::entry_t head;
    logic            push;
    logic            pop;
    logic            fifo_full;
    logic            fifo_valid;

    // classification front
    rbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry),
        .cfg        (cfg)
    );

    // item queue
    rbc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (fifo_full),
        .not_empty  (fifo_valid),
        .head       (head)
    );

    // accumulation and summary back
    rbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_valid (fifo_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

endmodule
`default_nettype wire
